[design/lsp_pkg.sv]
// shared types and codes for the lifo stack with peek
`timescale 1ns / 1ps

package lsp_pkg;

    // operation codes carried in the input item's tuser
    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_POP  = 2'd1;
    localparam logic [1:0] MODE_PEEK = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_BADPOS    = 2'd3;

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    // commands from controller to datapath
    typedef struct packed {
        logic exec;  // accept item: access memory, update count, stage result
        logic load;  // move staged result into output register
    } t_cmd;

endpackage

[design/lsp_ctrl.sv]
// controller state machine: input handshake, sequencing and output valid
`timescale 1ns / 1ps

module lsp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    output logic          o_s_ready,
    output logic          o_m_valid,
    input  logic          i_m_ready,
    output lsp_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RESP = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // command decode
    assign o_s_ready  = (r_state == S_IDLE);
    assign o_cmd.exec = i_s_valid && (r_state == S_IDLE);
    assign o_cmd.load = (r_state == S_RESP) && (!r_out_valid || i_m_ready);
    assign o_m_valid  = r_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.exec) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (o_cmd.load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid tracking
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // an accepted item always moves on to the response state
    a_exec_to_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> (r_state == S_RESP))
        else $error("accepted item did not reach response state");

    // the output register is only reloaded once its item is gone
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (!r_out_valid || i_m_ready))
        else $error("output register overwritten");

    // a held result keeps the next item waiting in the response state
    a_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RESP) && r_out_valid && !i_m_ready) |=> (r_state == S_RESP))
        else $error("response state left while output stalled");

    // a new result only appears out of the response state
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_RESP))
        else $error("output valid raised outside response state");

endmodule

[design/lsp_dp.sv]
// datapath: entry memory, depth count, capacity register and result registers
`timescale 1ns / 1ps

module lsp_dp #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32,
    parameter int CW         = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lsp_pkg::t_cmd                i_cmd,
    input  logic                         i_cfg_we,
    input  logic [CW-1:0]                i_cfg_wdata,
    input  logic [lsp_pkg::MODE_W-1:0]   i_mode,
    input  logic [DATA_WIDTH-1:0]        i_push_value,
    input  logic [CW-1:0]                i_position,
    output logic [DATA_WIDTH-1:0]        o_data,
    output logic [lsp_pkg::STATUS_W-1:0] o_status,
    output logic [CW-1:0]                o_count,
    output logic                         o_empty_res,
    output logic                         o_full_res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [CW-1:0]         r_cap;
    logic [CW-1:0]         cap_use;
    logic [CW-1:0]         peek_idx;
    logic [AW-1:0]         addr;
    logic                  wr_en;
    logic                  rd_en;
    logic                  use_mem;
    logic [lsp_pkg::STATUS_W-1:0] status;

    // staged result between memory access and output register
    logic                         r_st_use_mem;
    logic [lsp_pkg::STATUS_W-1:0] r_st_status;
    logic [CW-1:0]                r_st_count;
    logic                         r_st_empty;
    logic                         r_st_full;

    // capacity saturated into 1..DEPTH
    always_comb begin
        cap_use = r_cap;
        if (r_cap == '0) begin
            cap_use = CW'(1);
        end else if (r_cap > DEPTH_C) begin
            cap_use = DEPTH_C;
        end
    end

    assign peek_idx = r_count - i_position;

    // operation decode against current count
    always_comb begin
        n_count = r_count;
        status  = lsp_pkg::ST_OK;
        wr_en   = 1'b0;
        rd_en   = 1'b0;
        use_mem = 1'b0;
        addr    = r_count[AW-1:0];
        case (i_mode)
            lsp_pkg::MODE_PUSH: begin
                if (r_count >= cap_use) begin
                    status = lsp_pkg::ST_OVERFLOW;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            lsp_pkg::MODE_POP: begin
                if (r_count == '0) begin
                    status = lsp_pkg::ST_UNDERFLOW;
                end else begin
                    n_count = r_count - CW'(1);
                    addr    = n_count[AW-1:0];
                    rd_en   = 1'b1;
                    use_mem = 1'b1;
                end
            end
            lsp_pkg::MODE_PEEK: begin
                if ((i_position == '0) || (i_position > r_count)) begin
                    status = lsp_pkg::ST_BADPOS;
                end else begin
                    addr    = peek_idx[AW-1:0];
                    rd_en   = 1'b1;
                    use_mem = 1'b1;
                end
            end
            default: begin
                status = lsp_pkg::ST_OK;
            end
        endcase
    end

    // entry memory, one write or one registered read per item
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_mem[addr] <= i_push_value;
        end
        if (i_cmd.exec && rd_en) begin
            r_rd_data <= r_mem[addr];
        end
    end

    // depth count and capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cap   <= DEPTH_C;
        end else begin
            if (i_cmd.exec) begin
                r_count <= n_count;
            end
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    // stage result fields alongside the memory read
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_st_use_mem <= use_mem;
            r_st_status  <= status;
            r_st_count   <= n_count;
            r_st_empty   <= (n_count == '0);
            r_st_full    <= (n_count >= cap_use);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_data      <= r_st_use_mem ? r_rd_data : '1;
            o_status    <= r_st_status;
            o_count     <= r_st_count;
            o_empty_res <= r_st_empty;
            o_full_res  <= r_st_full;
        end
    end

endmodule

[design/lifo_stack_with_peek_core.sv]
// top level of the lifo stack with peek: stream ports, controller and datapath
// the registered read of the entry memory is followed by the load of the output register
// in the response state; a new item is taken only in the idle state, after that load; a
// result waiting at the output does not block acceptance of the next item, which then
// holds until the output register frees
// reset: count clears to zero, capacity returns to DEPTH; entry memory is not cleared
`timescale 1ns / 1ps

module lifo_stack_with_peek_core #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32,
    localparam int CW        = $clog2(DEPTH + 1),
    localparam int S_TDATA_W = ((DATA_WIDTH + CW + 7) / 8) * 8,
    localparam int M_RAW_W   = DATA_WIDTH + lsp_pkg::STATUS_W + CW + 2,
    localparam int M_TDATA_W = ((M_RAW_W + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CW-1:0]              i_cfg_wdata,     // capacity
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [S_TDATA_W-1:0]       s_axis_tdata,    // push_value, position, zero fill
    input  logic [lsp_pkg::MODE_W-1:0] s_axis_tuser,    // mode
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [M_TDATA_W-1:0]       m_axis_tdata     // data, status, count, empty_res,
                                                        // full_res, zero fill
);

    lsp_pkg::t_cmd cmd;

    logic [DATA_WIDTH-1:0]        data;
    logic [lsp_pkg::STATUS_W-1:0] status;
    logic [CW-1:0]                count;
    logic                         empty_res;
    logic                         full_res;

    // controller
    lsp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_cmd     (cmd)
    );

    // datapath
    lsp_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CW         (CW)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_mode       (s_axis_tuser),
        .i_push_value (s_axis_tdata[DATA_WIDTH-1:0]),
        .i_position   (s_axis_tdata[DATA_WIDTH +: CW]),
        .o_data       (data),
        .o_status     (status),
        .o_count      (count),
        .o_empty_res  (empty_res),
        .o_full_res   (full_res)
    );

    // result packing, lowest field first
    assign m_axis_tdata = M_TDATA_W'({full_res, empty_res, count, status, data});

endmodule

[tb/lifo_result_checker.sv]
// checker for the lifo stack: predicts each result and compares it with the output stream
`timescale 1ns / 1ps

module lifo_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,   // capacity
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,     // push_value, position, zero fill
    input  logic [1:0]  i_s_tuser,     // mode
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] i_m_tdata,     // data, status, count, empty_res, full_res, zero fill
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_refused
);

    localparam int DEPTH = 64;
    localparam int DW    = 32;
    localparam int CW    = 7;

    typedef struct {
        logic [DW-1:0] data;
        logic [1:0]    status;
        logic [CW-1:0] count;
        logic          empty_flag;
        logic          full_flag;
    } t_stack_result;

    // own copy of the stack state and the capacity register
    logic [DW-1:0] word_mem [DEPTH];
    int unsigned   held_words;
    int unsigned   capacity_reg;

    t_stack_result expected_results [$];
    t_stack_result want_res;
    t_stack_result new_res;
    int            fail_cnt;
    int            checked_cnt;
    int            refused_cnt;

    initial begin
        held_words   = 0;
        capacity_reg = DEPTH;
        fail_cnt     = 0;
        checked_cnt  = 0;
        refused_cnt  = 0;
    end

    // apply one operation to the stack copy and return the result it yields
    function automatic t_stack_result run_stack_op(input logic [1:0] mode,
                                                   input logic [DW-1:0] word,
                                                   input logic [CW-1:0] pos);
        t_stack_result res;
        int unsigned   cap;
        // register value saturated into 1..DEPTH
        cap = (capacity_reg < 1) ? 1 : ((capacity_reg > DEPTH) ? DEPTH : capacity_reg);
        res.data   = '1;
        res.status = lsp_pkg::ST_OK;
        case (mode)
            lsp_pkg::MODE_PUSH: begin
                if (held_words >= cap) begin
                    res.status = lsp_pkg::ST_OVERFLOW;
                end else begin
                    word_mem[held_words] = word;
                    held_words++;
                end
            end
            lsp_pkg::MODE_POP: begin
                if (held_words == 0) begin
                    res.status = lsp_pkg::ST_UNDERFLOW;
                end else begin
                    held_words--;
                    res.data = word_mem[held_words];
                end
            end
            lsp_pkg::MODE_PEEK: begin
                if (pos == 0 || pos > held_words) begin
                    res.status = lsp_pkg::ST_BADPOS;
                end else begin
                    res.data = word_mem[held_words - pos];
                end
            end
            // unused mode: nothing happens
            default: ;
        endcase
        res.count      = CW'(held_words);
        res.empty_flag = (held_words == 0);
        res.full_flag  = (held_words >= cap);
        return res;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    // results are checked before new items are predicted at the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_words   = 0;
            capacity_reg = DEPTH;
            expected_results.delete();
        end else begin
            if (i_cfg_we)
                capacity_reg = i_cfg_wdata;

            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with no item waiting, expected none, actual %h",
                             $time, i_m_tdata);
                    fail_cnt++;
                end else begin
                    want_res = expected_results.pop_front();
                    check_field("data",      want_res.data,       i_m_tdata[31:0]);
                    check_field("status",    want_res.status,     i_m_tdata[33:32]);
                    check_field("count",     want_res.count,      i_m_tdata[40:34]);
                    check_field("empty_res", want_res.empty_flag, i_m_tdata[41]);
                    check_field("full_res",  want_res.full_flag,  i_m_tdata[42]);
                    check_field("zero fill", 0,                   i_m_tdata[47:43]);
                    checked_cnt++;
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                new_res = run_stack_op(i_s_tuser, i_s_tdata[31:0], i_s_tdata[38:32]);
                if (new_res.status != lsp_pkg::ST_OK)
                    refused_cnt++;
                expected_results.push_back(new_res);
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_cnt;
        o_checked    <= checked_cnt;
        o_refused    <= refused_cnt;
    end

endmodule

[tb/tb_lifo_stack_with_peek_core.sv]
// testbench top for the lifo stack with peek: stimulus, stalls and verdict
`timescale 1ns / 1ps

module tb_lifo_stack_with_peek_core;

    localparam logic [1:0] MODE_IGNORED = 2'd3;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         NUM_PHASES   = 10;
    localparam int         PHASE_ITEMS  = 190;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [6:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // push_value, position, zero fill
    logic [1:0]  s_tuser;    // mode
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;    // data, status, count, empty_res, full_res, zero fill

    int fail_count;
    int pending;
    int checked;
    int refused;

    int idle_pct;
    int stall_pct;
    int items_sent;
    int cap_writes;
    int cycle_cnt;

    lifo_stack_with_peek_core i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    lifo_result_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_refused    (refused)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver side: random stalls on the result stream
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // offer one item, with random idle cycles ahead of it, and wait for acceptance
    task automatic send_item(input logic [1:0] mode, input logic [31:0] word,
                             input logic [6:0] pos);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pos, word};
        s_tuser  <= mode;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // capacity is only written with nothing in flight
    task automatic write_capacity(input logic [6:0] value);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cap_writes++;
    endtask

    function automatic logic [31:0] pick_word();
        logic [31:0] corner [5];
        corner = '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        if ($urandom_range(0, 9) == 0)
            return corner[$urandom_range(0, 4)];
        return $urandom;
    endfunction

    function automatic logic [6:0] pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 7'($urandom_range(1, 8));
        if (r < 80)
            return 7'($urandom_range(1, 64));
        return 7'($urandom_range(0, 127));
    endfunction

    // stimulus
    initial begin
        int          phase_cap [NUM_PHASES];
        int          phase_push [NUM_PHASES];
        int          r;
        logic [1:0]  mode;

        phase_cap  = '{127, 64, 5, 64, 0, 2, 65, 0, 64, 1};
        phase_push = '{ 70, 75, 30, 60, 50, 50, 70, 50, 30, 50};
        phase_cap[7] = $urandom_range(3, 63);

        idle_pct   = 33;
        stall_pct  = 33;
        items_sent = 0;
        cap_writes = 0;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= lsp_pkg::MODE_PUSH;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stack, unused mode and word extremes at reset capacity
        send_item(lsp_pkg::MODE_POP,  32'h0, 7'd0);
        send_item(lsp_pkg::MODE_PEEK, 32'h0, 7'd1);
        send_item(MODE_IGNORED,       32'h0, 7'd0);
        send_item(lsp_pkg::MODE_PUSH, 32'h7FFF_FFFF, 7'd0);
        send_item(lsp_pkg::MODE_PUSH, 32'h8000_0000, 7'd127);
        send_item(lsp_pkg::MODE_PUSH, 32'h0000_0000, 7'd0);
        send_item(lsp_pkg::MODE_PUSH, 32'hFFFF_FFFF, 7'd0);
        send_item(lsp_pkg::MODE_PEEK, 32'h0, 7'd0);
        send_item(lsp_pkg::MODE_PEEK, 32'h0, 7'd1);
        send_item(lsp_pkg::MODE_PEEK, 32'h0, 7'd4);
        send_item(lsp_pkg::MODE_PEEK, 32'h0, 7'd5);
        send_item(lsp_pkg::MODE_PEEK, 32'hFFFF_FFFF, 7'd127);
        send_item(MODE_IGNORED,       32'hFFFF_FFFF, 7'd127);
        send_item(lsp_pkg::MODE_POP,  32'h0, 7'd0);

        // capacity dropped below the count: pushes refused until pops catch up
        write_capacity(7'd1);
        send_item(lsp_pkg::MODE_PUSH, 32'h1234_5678, 7'd0);
        send_item(lsp_pkg::MODE_POP,  32'h0, 7'd0);
        send_item(lsp_pkg::MODE_POP,  32'h0, 7'd0);
        send_item(lsp_pkg::MODE_POP,  32'h0, 7'd0);
        send_item(lsp_pkg::MODE_PUSH, 32'h5A5A_A5A5, 7'd0);
        send_item(lsp_pkg::MODE_PUSH, 32'hA5A5_5A5A, 7'd0);

        // zero capacity acts as one
        write_capacity(7'd0);
        send_item(lsp_pkg::MODE_PUSH, 32'h0F0F_0F0F, 7'd0);
        send_item(lsp_pkg::MODE_POP,  32'h0, 7'd0);
        send_item(lsp_pkg::MODE_PUSH, 32'hF0F0_F0F0, 7'd0);
        send_item(lsp_pkg::MODE_POP,  32'h0, 7'd0);

        // random phases, each with its own capacity and push bias
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_capacity(7'(phase_cap[p]));
            idle_pct  = (p == 3) ? 0 : 33;
            stall_pct = (p == 3) ? 0 : 33;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < phase_push[p])
                    mode = lsp_pkg::MODE_PUSH;
                else if (r < 83)
                    mode = lsp_pkg::MODE_POP;
                else if (r < 97)
                    mode = lsp_pkg::MODE_PEEK;
                else
                    mode = MODE_IGNORED;
                send_item(mode, pick_word(), pick_position());
            end
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);

        $display("Covered %0d items over %0d capacity writes, from empty to full and back",
                 items_sent, cap_writes);
        $display("Checked %0d results, %0d of them refused operations", checked, refused);
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
